### design/lfba_pkg.sv
// shared types and constants of the lorentz field boost accumulator
`default_nettype none
package lfba_pkg;

    localparam int ADDR_W  = 5;
    localparam int FIELD_W = 48;
    localparam logic [31:0] GAMMA_ONE = 32'h0100_0000;

    typedef enum logic [2:0] {
        REG_GAMMA,
        REG_BETA_X,
        REG_BETA_Y,
        REG_BETA_Z,
        REG_UNIT_X,
        REG_UNIT_Y,
        REG_UNIT_Z,
        REG_MAG_NEG
    } reg_idx_t;

    typedef enum logic {
        OP_ACCUMULATE = 1'b0,
        OP_CLEAR      = 1'b1
    } op_t;

    typedef struct packed {
        logic               opcode;
        logic [11:0]        cell_index;
        logic signed [31:0] rest_ex;
        logic signed [31:0] rest_ey;
        logic signed [31:0] rest_ez;
    } in_item_t;

    typedef struct packed {
        logic [11:0]               out_index;
        logic signed [FIELD_W-1:0] total_ex;
        logic signed [FIELD_W-1:0] total_ey;
        logic signed [FIELD_W-1:0] total_ez;
        logic signed [FIELD_W-1:0] total_cbx;
        logic signed [FIELD_W-1:0] total_cby;
        logic signed [FIELD_W-1:0] total_cbz;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        gamma_factor;
        logic signed [31:0] beta_x;
        logic signed [31:0] beta_y;
        logic signed [31:0] beta_z;
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic               magnetic_negate;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [11:0] cell_idx;
    } tag_t;

    // boosted increments of one item, ready for accumulation
    typedef struct packed {
        tag_t                    tag;
        logic [2:0][FIELD_W-1:0] lab_e;
        logic [2:0][FIELD_W-1:0] lab_cb;
    } boost_t;

endpackage
`default_nettype wire

### design/lfba_cfg.sv
// apb register bank holding the boost parameters
`default_nettype none
module lfba_cfg
    import lfba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gamma_factor    <= GAMMA_ONE;
            cfg_reg.beta_x          <= '0;
            cfg_reg.beta_y          <= '0;
            cfg_reg.beta_z          <= '0;
            cfg_reg.unit_x          <= '0;
            cfg_reg.unit_y          <= '0;
            cfg_reg.unit_z          <= '0;
            cfg_reg.magnetic_negate <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_GAMMA:   cfg_reg.gamma_factor    <= pwdata;
                REG_BETA_X:  cfg_reg.beta_x          <= pwdata;
                REG_BETA_Y:  cfg_reg.beta_y          <= pwdata;
                REG_BETA_Z:  cfg_reg.beta_z          <= pwdata;
                REG_UNIT_X:  cfg_reg.unit_x          <= pwdata;
                REG_UNIT_Y:  cfg_reg.unit_y          <= pwdata;
                REG_UNIT_Z:  cfg_reg.unit_z          <= pwdata;
                REG_MAG_NEG: cfg_reg.magnetic_negate <= pwdata[0];
                default:     cfg_reg.magnetic_negate <= cfg_reg.magnetic_negate;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAMMA:   prdata = cfg_reg.gamma_factor;
            REG_BETA_X:  prdata = cfg_reg.beta_x;
            REG_BETA_Y:  prdata = cfg_reg.beta_y;
            REG_BETA_Z:  prdata = cfg_reg.beta_z;
            REG_UNIT_X:  prdata = cfg_reg.unit_x;
            REG_UNIT_Y:  prdata = cfg_reg.unit_y;
            REG_UNIT_Z:  prdata = cfg_reg.unit_z;
            REG_MAG_NEG: prdata = {31'd0, cfg_reg.magnetic_negate};
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### design/lfba_front.sv
// front end: cell reduction and the item queue
`default_nettype none
module lfba_front
    import lfba_pkg::*;
#(
    parameter int GRID_CELLS = 4096
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  in_item_t      item,
    input  wire logic     pop,
    output logic          q_valid,
    output in_item_t      q_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int RECIP = (1 << 24) / GRID_CELLS;

    in_item_t        q_reg [DEPTH];
    logic [PW:0]     wp_reg, rp_reg;
    logic [PW:0]     count;
    logic            push;
    logic [35:0]     qprod;
    logic [32:0]     qg;
    logic [12:0]     rem;
    logic [32:0]     rem_w;
    logic [32:0]     cell_w;
    in_item_t        reduced;

    // index modulo grid size by reciprocal estimate and one correction
    always_comb
    begin
        qprod  = 36'(item.cell_index) * 36'(RECIP);
        qg     = 33'(qprod[35:24]) * 33'(GRID_CELLS);
        rem    = 13'({1'b0, item.cell_index}) - qg[12:0];
        rem_w  = 33'(rem);
        cell_w = (rem_w >= 33'(GRID_CELLS)) ? rem_w - 33'(GRID_CELLS) : rem_w;
        reduced            = item;
        reduced.cell_index = cell_w[11:0];
    end

    assign count      = wp_reg - rp_reg;
    assign item_ready = (count != (PW+1)'(DEPTH));
    assign q_valid    = (count != '0);
    assign q_item     = q_reg[rp_reg[PW-1:0]];
    assign push       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop && q_valid)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg[PW-1:0]] <= reduced;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= (PW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !(pop && q_valid)) |=> (count == $past(count) + 1'b1))
        else $error("queue lost an item");
`endif

endmodule
`default_nettype wire

### design/lfba_boost.sv
// back end arithmetic: lorentz boost of the rest-frame field
`default_nettype none
module lfba_boost
    import lfba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  in_item_t  in_item,
    input  cfg_t      cfg,
    output logic      out_valid,
    output boost_t    out_data
);

    logic signed [31:0] e [3];
    logic signed [31:0] u [3];
    logic signed [31:0] ba [3];
    logic signed [31:0] bb [3];
    logic signed [31:0] ea [3];
    logic signed [31:0] eb [3];
    logic signed [32:0] gs;
    logic signed [32:0] gm1;

    logic signed [63:0] p_du [3];
    logic signed [64:0] p_ge [3];
    logic signed [63:0] p_ca [3];
    logic signed [63:0] p_cb [3];
    logic signed [68:0] p_sc;
    logic signed [67:0] p_m [3];
    logic signed [76:0] p_scu [3];
    logic signed [35:0] dot;
    logic signed [34:0] cx [3];

    logic [4:0]         v_reg;
    tag_t               t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [33:0] du1_reg [3];
    logic signed [40:0] ge1_reg [3], ge2_reg [3], ge3_reg [3], ge4_reg [3];
    logic signed [33:0] ca1_reg [3], cb1_reg [3];
    logic signed [35:0] dot2_reg;
    logic signed [34:0] cx2_reg [3];
    logic signed [44:0] sc3_reg;
    logic signed [43:0] m3_reg [3], m4_reg [3];
    logic signed [46:0] scu4_reg [3];
    logic signed [47:0] l5_reg [3];
    logic signed [44:0] mm5_reg [3];

    always_comb
    begin
        e[0] = in_item.rest_ex;
        e[1] = in_item.rest_ey;
        e[2] = in_item.rest_ez;
        u[0] = cfg.unit_x;
        u[1] = cfg.unit_y;
        u[2] = cfg.unit_z;
        // beta x e as ba*ea - bb*eb per component
        ba[0] = cfg.beta_y;  ea[0] = in_item.rest_ez;
        bb[0] = cfg.beta_z;  eb[0] = in_item.rest_ey;
        ba[1] = cfg.beta_z;  ea[1] = in_item.rest_ex;
        bb[1] = cfg.beta_x;  eb[1] = in_item.rest_ez;
        ba[2] = cfg.beta_x;  ea[2] = in_item.rest_ey;
        bb[2] = cfg.beta_y;  eb[2] = in_item.rest_ex;
        gs  = $signed({1'b0, cfg.gamma_factor});
        gm1 = gs - $signed({1'b0, GAMMA_ONE});
        for (int i = 0; i < 3; i++)
        begin
            p_du[i]  = e[i] * u[i];
            p_ge[i]  = gs * e[i];
            p_ca[i]  = ba[i] * ea[i];
            p_cb[i]  = bb[i] * eb[i];
            cx[i]    = ca1_reg[i] - cb1_reg[i];
            p_m[i]   = gs * cx2_reg[i];
            p_scu[i] = sc3_reg * u[i];
        end
        dot  = du1_reg[0] + du1_reg[1] + du1_reg[2];
        p_sc = gm1 * dot2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // part-selects of the products floor the fixed point shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= '{opcode: in_item.opcode, cell_idx: in_item.cell_index};
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
            dot2_reg <= dot;
            sc3_reg  <= p_sc[68:24];
            for (int i = 0; i < 3; i++)
            begin
                du1_reg[i]  <= p_du[i][63:30];
                ge1_reg[i]  <= p_ge[i][64:24];
                ca1_reg[i]  <= p_ca[i][63:30];
                cb1_reg[i]  <= p_cb[i][63:30];
                ge2_reg[i]  <= ge1_reg[i];
                cx2_reg[i]  <= cx[i];
                ge3_reg[i]  <= ge2_reg[i];
                m3_reg[i]   <= p_m[i][67:24];
                ge4_reg[i]  <= ge3_reg[i];
                m4_reg[i]   <= m3_reg[i];
                scu4_reg[i] <= p_scu[i][76:30];
                l5_reg[i]   <= 48'(ge4_reg[i]) - 48'(scu4_reg[i]);
                mm5_reg[i]  <= cfg.magnetic_negate ? -45'(m4_reg[i]) : 45'(m4_reg[i]);
            end
        end
    end

    always_comb
    begin
        out_data.tag = t5_reg;
        for (int i = 0; i < 3; i++)
        begin
            out_data.lab_e[i]  = l5_reg[i];
            out_data.lab_cb[i] = FIELD_W'(mm5_reg[i]);
        end
    end

    assign out_valid = v_reg[4];

endmodule
`default_nettype wire

### design/lfba_accum.sv
// back end accumulation: per-cell memory update and result register
`default_nettype none
module lfba_accum
    import lfba_pkg::*;
#(
    parameter int GRID_CELLS = 4096,
    parameter int ACC_WIDTH  = 48
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  boost_t    in_data,
    output logic      en,
    output logic      result_valid,
    input  wire logic result_ready,
    output out_item_t result
);

    localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int CW = (AW > 12) ? AW : 12;
    localparam int A  = ACC_WIDTH;
    localparam int SW = ((A > FIELD_W) ? A : FIELD_W) + 1;
    localparam int OW = (A > FIELD_W) ? A : FIELD_W;
    localparam logic signed [SW-1:0] ACC_MAX = {{(SW-A+1){1'b0}}, {(A-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

    logic [6*A-1:0]      mem [GRID_CELLS];
    logic [6*A-1:0]      rd_reg;
    logic                v6_reg;
    boost_t              b6_reg;
    logic                fwd_valid_reg;
    logic [11:0]         fwd_cell_reg;
    logic [6*A-1:0]      fwd_data_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [CW-1:0]       rd_ext, wr_ext;
    logic [6*A-1:0]      old_word, new_word;
    logic signed [A-1:0]  acc_old [6];
    logic signed [A-1:0]  acc_new [6];
    logic signed [FIELD_W-1:0] inc [6];
    logic signed [SW-1:0] sum [6];
    logic signed [OW-1:0] wide [6];
    out_item_t           res;

    assign en     = !out_valid_reg || result_ready;
    assign rd_ext = CW'(in_data.tag.cell_idx);
    assign wr_ext = CW'(b6_reg.tag.cell_idx);

    always_comb
    begin
        // the item one ahead wrote its cell in the cycle this read was taken
        old_word = (fwd_valid_reg && fwd_cell_reg == b6_reg.tag.cell_idx) ? fwd_data_reg : rd_reg;
        for (int i = 0; i < 3; i++)
        begin
            inc[i]   = b6_reg.lab_e[i];
            inc[i+3] = b6_reg.lab_cb[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            acc_old[i] = old_word[i*A +: A];
            sum[i]     = SW'(acc_old[i]) + SW'(inc[i]);
            if (b6_reg.tag.opcode == OP_CLEAR)
                acc_new[i] = '0;
            else if (sum[i] > ACC_MAX)
                acc_new[i] = ACC_MAX[A-1:0];
            else if (sum[i] < ACC_MIN)
                acc_new[i] = ACC_MIN[A-1:0];
            else
                acc_new[i] = sum[i][A-1:0];
            new_word[i*A +: A] = acc_new[i];
            wide[i]    = OW'(acc_new[i]);
        end
        res.out_index = b6_reg.tag.cell_idx;
        res.total_ex  = wide[0][FIELD_W-1:0];
        res.total_ey  = wide[1][FIELD_W-1:0];
        res.total_ez  = wide[2][FIELD_W-1:0];
        res.total_cbx = wide[3][FIELD_W-1:0];
        res.total_cby = wide[4][FIELD_W-1:0];
        res.total_cbz = wide[5][FIELD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= mem[rd_ext[AW-1:0]];
            b6_reg <= in_data;
            if (v6_reg)
                mem[wr_ext[AW-1:0]] <= new_word;
            fwd_cell_reg <= b6_reg.tag.cell_idx;
            fwd_data_reg <= new_word;
            out_reg      <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg        <= in_valid;
            fwd_valid_reg <= v6_reg;
            out_valid_reg <= v6_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v6_reg && b6_reg.tag.opcode == OP_CLEAR) |=>
        (out_reg.total_ex == '0 && out_reg.total_cbz == '0))
        else $error("clear item gave nonzero totals");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result changed while stalled");
`endif

endmodule
`default_nettype wire

### design/lorentz_field_boost_accumulate_core.sv
// lorentz field boost accumulator: top level
//
// items arrive on item_valid/item_ready carrying an opcode, a cell index and
// the rest-frame electric vector; each item yields one result on
// result_valid/result_ready with the cell's updated electric and c*magnetic
// totals. a clear item zeroes the cell and reports zeros.
// the front reduces the cell index modulo the grid size and queues up to four
// items; the back runs a five-stage multiply pipeline and then a
// read-modify-write of the cell memory with forwarding between neighbours.
// throughput is one item per cycle while the receiver does not stall; an item
// passes from the queue through the multiply chain e.u -> dot -> scale by
// gamma-1 -> times unit -> subtract, then through the memory read register
// and the update into the result register.
// when the receiver stalls the whole back end holds; the queue keeps taking
// items until four are waiting, then item_ready drops.
// reset clears the handshake state and loads gamma one, all other parameters zero; the
// cell memory is not cleared, so software clears every cell before use.
// parameters must be written over the apb port only while the block is idle; the block does not enforce this.
`default_nettype none
module lorentz_field_boost_accumulate_core
    import lfba_pkg::*;
#(
    parameter int GRID_CELLS = 4096,
    parameter int ACC_WIDTH  = 48
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  in_item_t               item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output out_item_t              result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t     cfg;
    logic     en;
    logic     q_valid;
    in_item_t q_item;
    logic     pop;
    logic     b_valid;
    boost_t   b_data;

    assign pop = en && q_valid;

    lfba_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfba_front #(.GRID_CELLS(GRID_CELLS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_item     (q_item)
    );

    lfba_boost u_boost (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pop),
        .in_item   (q_item),
        .cfg       (cfg),
        .out_valid (b_valid),
        .out_data  (b_data)
    );

    lfba_accum #(.GRID_CELLS(GRID_CELLS), .ACC_WIDTH(ACC_WIDTH)) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (b_valid),
        .in_data      (b_data),
        .en           (en),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the lorentz field boost accumulator: directed table, random phases, scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lfba_pkg::*;

    localparam int  CELLS      = 4096;
    localparam int  SETTLE     = 12;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  RAND_ITEMS = 100;
    localparam longint ACC_HI  = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO  = -(64'sd1 <<< 47);
    localparam int  Q30_ONE    = 32'sd1073741824;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic      pready;

    lorentz_field_boost_accumulate_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the block: registers and per-cell totals
    cfg_t   shadow_cfg;
    longint tot_e  [3][CELLS];
    longint tot_cb [3][CELLS];
    bit     cell_cleared [CELLS];
    int     cleared_cells [$];

    out_item_t totals_due [$];
    int  errors;
    int  items_sent;
    int  clears_sent;
    int  results_seen;
    int  cycles;
    bit  hold_req;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t want;
    } row_t;
    row_t directed [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // floor(a*b / 2^k), saturated to 64 bits
    function automatic longint mul_floor(longint a, longint b, int k);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = a;
        p = p * 128'(signed'(b));
        q = p >>> k;
        if (q > 128'sh7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (q < -128'sh8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return longint'(q);
    endfunction

    function automatic longint acc_add(longint a, longint b);
        if (a > ACC_HI) a = ACC_HI;
        if (a < ACC_LO) a = ACC_LO;
        if (b > 0 && a > ACC_HI - b) return ACC_HI;
        if (b < 0 && a < ACC_LO - b) return ACC_LO;
        return a + b;
    endfunction

    // boosts one item, folds it into the cell totals and returns the new totals
    function automatic out_item_t boost_and_accumulate(in_item_t it);
        out_item_t r;
        longint e [3];
        longint u [3];
        longint b [3];
        longint lab [3];
        longint cr [3];
        longint mg [3];
        longint g;
        longint dot;
        longint sc;
        int c;
        c = it.cell_index % CELLS;
        if (op_t'(it.opcode) == OP_CLEAR)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tot_e[i][c] = 0;
                tot_cb[i][c] = 0;
            end
        end
        else
        begin
            e[0] = it.rest_ex; e[1] = it.rest_ey; e[2] = it.rest_ez;
            u[0] = shadow_cfg.unit_x; u[1] = shadow_cfg.unit_y; u[2] = shadow_cfg.unit_z;
            b[0] = shadow_cfg.beta_x; b[1] = shadow_cfg.beta_y; b[2] = shadow_cfg.beta_z;
            g = {32'b0, shadow_cfg.gamma_factor};
            dot = mul_floor(e[0], u[0], 30) + mul_floor(e[1], u[1], 30)
                + mul_floor(e[2], u[2], 30);
            sc = mul_floor(g - longint'(GAMMA_ONE), dot, 24);
            for (int i = 0; i < 3; i++)
                lab[i] = mul_floor(g, e[i], 24) - mul_floor(sc, u[i], 30);
            cr[0] = mul_floor(b[1], e[2], 30) - mul_floor(b[2], e[1], 30);
            cr[1] = mul_floor(b[2], e[0], 30) - mul_floor(b[0], e[2], 30);
            cr[2] = mul_floor(b[0], e[1], 30) - mul_floor(b[1], e[0], 30);
            for (int i = 0; i < 3; i++)
            begin
                mg[i] = mul_floor(g, cr[i], 24);
                if (shadow_cfg.magnetic_negate)
                    mg[i] = -mg[i];
                tot_e[i][c] = acc_add(tot_e[i][c], lab[i]);
                tot_cb[i][c] = acc_add(tot_cb[i][c], mg[i]);
            end
        end
        r.out_index = 12'(c);
        r.total_ex  = tot_e[0][c][FIELD_W-1:0];
        r.total_ey  = tot_e[1][c][FIELD_W-1:0];
        r.total_ez  = tot_e[2][c][FIELD_W-1:0];
        r.total_cbx = tot_cb[0][c][FIELD_W-1:0];
        r.total_cby = tot_cb[1][c][FIELD_W-1:0];
        r.total_cbz = tot_cb[2][c][FIELD_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic check_field(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch(what, longint'(got), longint'(want));
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (totals_due.size() == 0)
                report_mismatch("unexpected result, index", longint'(result.out_index), 0);
            else
            begin
                w = totals_due.pop_front();
                check_field("out_index", 48'(result.out_index), 48'(w.out_index));
                check_field("total_ex", result.total_ex, w.total_ex);
                check_field("total_ey", result.total_ey, w.total_ey);
                check_field("total_ez", result.total_ez, w.total_ez);
                check_field("total_cbx", result.total_cbx, w.total_cbx);
                check_field("total_cby", result.total_cby, w.total_cby);
                check_field("total_cbz", result.total_cbz, w.total_cbz);
            end
        end
    end

    // receiver: ready pattern redrawn at random each span, with one long hold-off on request
    initial
    begin
        int hold_cnt;
        int mode;
        int span;
        hold_cnt = 0;
        mode = 0;
        span = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = 120;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = 64;
            end
            span--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_ready <= 1'b0;
            end
            else
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= ($urandom_range(0, 1) == 0);
                    2: result_ready <= ($urandom_range(0, 9) == 0);
                    default: result_ready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAMMA:   shadow_cfg.gamma_factor = v;
            REG_BETA_X:  shadow_cfg.beta_x = v;
            REG_BETA_Y:  shadow_cfg.beta_y = v;
            REG_BETA_Z:  shadow_cfg.beta_z = v;
            REG_UNIT_X:  shadow_cfg.unit_x = v;
            REG_UNIT_Y:  shadow_cfg.unit_y = v;
            REG_UNIT_Z:  shadow_cfg.unit_z = v;
            REG_MAG_NEG: shadow_cfg.magnetic_negate = v[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] g, int bx, int by, int bz,
                             int ux, int uy, int uz, bit neg);
        write_reg(REG_GAMMA, g);
        write_reg(REG_BETA_X, bx);
        write_reg(REG_BETA_Y, by);
        write_reg(REG_BETA_Z, bz);
        write_reg(REG_UNIT_X, ux);
        write_reg(REG_UNIT_Y, uy);
        write_reg(REG_UNIT_Z, uz);
        write_reg(REG_MAG_NEG, {31'b0, neg});
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(in_item_t it, bit typed, out_item_t want);
        out_item_t p;
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        p = boost_and_accumulate(it);
        totals_due.push_back(typed ? want : p);
        items_sent++;
        if (op_t'(it.opcode) == OP_CLEAR)
        begin
            clears_sent++;
            if (!cell_cleared[it.cell_index])
            begin
                cell_cleared[it.cell_index] = 1'b1;
                cleared_cells.push_back(it.cell_index);
            end
        end
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (totals_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_q130();
        return $urandom_range(0, 32'h8000_0000) - Q30_ONE;
    endfunction

    function automatic in_item_t make_item(op_t op, logic [11:0] c,
                                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_item_t it;
        it.opcode = op;
        it.cell_index = c;
        it.rest_ex = x;
        it.rest_ey = y;
        it.rest_ez = z;
        return it;
    endfunction

    function automatic out_item_t make_totals(logic [11:0] c, longint ex, longint ey, longint ez);
        out_item_t r;
        r = '0;
        r.out_index = c;
        r.total_ex = ex[FIELD_W-1:0];
        r.total_ey = ey[FIELD_W-1:0];
        r.total_ez = ez[FIELD_W-1:0];
        return r;
    endfunction

    task automatic add_row(in_item_t it, bit typed, out_item_t want);
        row_t r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        directed.push_back(r);
    endtask

    // random phase: mostly accumulates into cleared cells, some clears anywhere
    task automatic random_phase(bit gaps);
        int left;
        int burst;
        in_item_t it;
        out_item_t none;
        none = '0;
        left = RAND_ITEMS;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                if ($urandom_range(0, 6) == 0)
                    it = make_item(OP_CLEAR, 12'($urandom), rand_field(), rand_field(),
                                   rand_field());
                else
                    it = make_item(OP_ACCUMULATE,
                                   12'(cleared_cells[$urandom_range(0, cleared_cells.size()-1)]),
                                   rand_field(), rand_field(), rand_field());
                offer(it, 1'b0, none);
                burst--;
                left--;
            end
            if (gaps)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        item_valid <= 1'b0;
    endtask

    initial
    begin
        out_item_t zero;
        zero = '0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        errors = 0;
        items_sent = 0;
        clears_sent = 0;
        results_seen = 0;
        cycles = 0;
        shadow_cfg = '0;
        shadow_cfg.gamma_factor = GAMMA_ONE;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset gamma is one and beta zero, so totals equal the raw field
        add_row(make_item(OP_CLEAR, 12'h000, 32'h1234_5678, 0, 0), 1, make_totals(12'h000, 0, 0, 0));
        add_row(make_item(OP_CLEAR, 12'hFFF, 0, 0, 0), 1, make_totals(12'hFFF, 0, 0, 0));
        add_row(make_item(OP_CLEAR, 12'hAAA, 32'hFFFF_FFFF, 0, 0), 1,
                make_totals(12'hAAA, 0, 0, 0));
        add_row(make_item(OP_CLEAR, 12'h555, 0, 32'hFFFF_FFFF, 0), 1,
                make_totals(12'h555, 0, 0, 0));
        add_row(make_item(OP_ACCUMULATE, 12'h000, 1, -1, 0), 1, make_totals(12'h000, 1, -1, 0));
        add_row(make_item(OP_ACCUMULATE, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1,
                make_totals(12'hFFF, 64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF));
        add_row(make_item(OP_ACCUMULATE, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0,
                zero);
        add_row(make_item(OP_ACCUMULATE, 12'h000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                0, zero);
        add_row(make_item(OP_ACCUMULATE, 12'hAAA, 32'hAAAA_AAAA, 32'h5555_5555, 0), 0, zero);
        add_row(make_item(OP_ACCUMULATE, 12'h555, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF),
                0, zero);
        add_row(make_item(OP_CLEAR, 12'h000, 0, 0, 0), 1, make_totals(12'h000, 0, 0, 0));
        add_row(make_item(OP_ACCUMULATE, 12'h000, 32'hFFFF_FFFF, 0, 1), 1,
                make_totals(12'h000, -1, 0, 1));
        foreach (directed[i])
            offer(directed[i].it, directed[i].typed, directed[i].want);
        drain();

        // extremes: largest gamma, full-scale velocity and unit vector, minus sign
        write_all(32'hFFFF_FFFF, Q30_ONE, -Q30_ONE, Q30_ONE, -Q30_ONE, Q30_ONE, -Q30_ONE, 1'b1);
        hold_req = 1'b1;
        random_phase(1'b0);
        drain();

        // gamma below one
        write_all(32'h0040_0000, rand_q130(), rand_q130(), rand_q130(),
                  rand_q130(), rand_q130(), rand_q130(), 1'b0);
        random_phase(1'b1);
        drain();

        // moderate boost with random direction
        write_all($urandom_range(GAMMA_ONE, 32'h0400_0000), rand_q130(), rand_q130(),
                  rand_q130(), rand_q130(), rand_q130(), rand_q130(),
                  1'($urandom_range(0, 1)));
        random_phase(1'b1);
        drain();

        // gamma exactly one with opposite full-scale velocity
        write_all(GAMMA_ONE, -Q30_ONE, Q30_ONE, -Q30_ONE, Q30_ONE, 0, -Q30_ONE, 1'b0);
        random_phase(1'b1);
        drain();

        $display("covered %0d items (%0d clears) over five register settings, %0d results checked",
                 items_sent, clears_sent, results_seen);
        $display("%0d cells in use, %0d mismatches", cleared_cells.size(), errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
